@@ hw/rtl/prf_pkg.sv @@
`timescale 1ns / 1ps

package prf_pkg;

    // Capture limit written into the interface description
    localparam int unsigned SNAP_LENGTH = 65535;

    // Radiotap and block constants
    localparam int unsigned RTAP_LEN     = 15;
    localparam logic [7:0]  EPB_TYPE     = 8'd6;
    localparam logic [7:0]  RTAP_PRESENT = 8'h2a;
    localparam logic [15:0] SNAP_LIMIT   = 16'(SNAP_LENGTH - RTAP_LEN);

    // Channel to frequency mapping
    localparam logic [15:0] FREQ_BASE_24 = 16'd2407;
    localparam logic [15:0] FREQ_CH14    = 16'd2484;
    localparam logic [15:0] FREQ_BASE_5  = 16'd5000;
    localparam logic [15:0] FLAGS_24     = 16'h00c0;
    localparam logic [15:0] FLAGS_5      = 16'h0140;
    localparam logic [7:0]  CH_LAST_24   = 8'd13;
    localparam logic [7:0]  CH_14        = 8'd14;

    // Burst lengths on the output side
    localparam int unsigned SEC_BYTES = 60;
    localparam int unsigned HDR_BYTES = 43;
    localparam int unsigned TRL_BYTES = 4;
    localparam int unsigned CNT_W     = $clog2(SEC_BYTES);

    // Command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Section header block followed by the interface description block
    localparam logic [7:0] SECTION_BYTES [0:SEC_BYTES-1] = '{
        8'h0a, 8'h0d, 8'h0d, 8'h0a, 8'd28, 8'd0, 8'd0, 8'd0,
        8'h4d, 8'h3c, 8'h2b, 8'h1a, 8'd1, 8'd0, 8'd0, 8'd0,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'd28, 8'd0, 8'd0, 8'd0,
        8'd1, 8'd0, 8'd0, 8'd0, 8'd32, 8'd0, 8'd0, 8'd0,
        8'd127, 8'd0, 8'd0, 8'd0,
        8'(SNAP_LENGTH), 8'(SNAP_LENGTH >> 8),
        8'(SNAP_LENGTH >> 16), 8'(SNAP_LENGTH >> 24),
        8'd9, 8'd0, 8'd1, 8'd0, 8'd6, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd32, 8'd0, 8'd0, 8'd0
    };

    // One queued command: which bursts to emit and what they carry
    typedef struct packed {
        logic        sec;
        logic        hdr;
        logic        data;
        logic        trl;
        logic [1:0]  pad;
        logic [7:0]  data_byte;
        logic [16:0] blk_len;
        logic [31:0] ts;
        logic [15:0] packet;
        logic [15:0] freq;
        logic [15:0] flags;
        logic [7:0]  sig;
    } t_cmd;

    // Output sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEC,
        PH_HDR,
        PH_DATA,
        PH_PAD,
        PH_TRL
    } t_phase;

    // Queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

@@ hw/rtl/prf_ifs.sv @@
`timescale 1ns / 1ps

// Input channel: one item per handshake
interface prf_in_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic [15:0]       frame_length;
    logic [31:0]       timestamp_us;
    logic [7:0]        radio_channel;
    logic signed [7:0] signal_dbm;
    logic [7:0]        data_byte;
    logic              is_first;
    logic              is_last;

    modport source (
        output valid, action, frame_length, timestamp_us, radio_channel,
               signal_dbm, data_byte, is_first, is_last,
        input  ready
    );
    modport sink (
        input  valid, action, frame_length, timestamp_us, radio_channel,
               signal_dbm, data_byte, is_first, is_last,
        output ready
    );
endinterface

// Output channel: one stream byte per handshake
interface prf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, out_byte, run_last, input ready);
    modport sink (input valid, out_byte, run_last, output ready);
endinterface

@@ hw/rtl/prf_front.sv @@
`timescale 1ns / 1ps

module prf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    prf_in_if.sink            i_in,
    input  prf_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output prf_pkg::t_cmd     o_cmd
);

    logic [15:0] r_kept, n_kept;
    logic [15:0] r_seen, n_seen;
    logic [16:0] r_blk, n_blk;
    logic        r_in_frame, n_in_frame;

    logic        accept;
    logic [15:0] kept_new;
    logic [15:0] packet;
    logic [16:0] rounded;
    logic [16:0] blk_new;
    logic [15:0] ch_x5;
    logic [15:0] freq;
    logic [15:0] flags;
    logic [15:0] base_kept;
    logic [15:0] base_seen;
    logic [16:0] base_blk;
    logic [15:0] seen_inc;
    logic [15:0] copied;
    logic [1:0]  align;
    logic        push;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // Header lengths from the first byte's frame length
    always_comb begin
        kept_new = (i_in.frame_length > prf_pkg::SNAP_LIMIT) ? prf_pkg::SNAP_LIMIT
                                                             : i_in.frame_length;
        packet   = 16'(prf_pkg::RTAP_LEN) + kept_new;
        rounded  = ({1'b0, packet} + 17'd3) & ~17'd3;
        blk_new  = rounded + 17'd32;
    end

    // Channel frequency and band flags
    always_comb begin
        ch_x5 = 16'(i_in.radio_channel) * 16'd5;
        if (i_in.radio_channel == 8'd0) begin
            freq  = 16'd0;
            flags = 16'd0;
        end else if (i_in.radio_channel <= prf_pkg::CH_LAST_24) begin
            freq  = prf_pkg::FREQ_BASE_24 + ch_x5;
            flags = prf_pkg::FLAGS_24;
        end else if (i_in.radio_channel == prf_pkg::CH_14) begin
            freq  = prf_pkg::FREQ_CH14;
            flags = prf_pkg::FLAGS_24;
        end else begin
            freq  = prf_pkg::FREQ_BASE_5 + ch_x5;
            flags = prf_pkg::FLAGS_5;
        end
    end

    // Classify the item and build its command
    always_comb begin
        n_kept     = r_kept;
        n_seen     = r_seen;
        n_blk      = r_blk;
        n_in_frame = r_in_frame;
        push       = 1'b0;
        base_kept  = i_in.is_first ? kept_new : r_kept;
        base_seen  = i_in.is_first ? 16'd0 : r_seen;
        base_blk   = i_in.is_first ? blk_new : r_blk;
        seen_inc   = (base_seen != 16'hffff) ? base_seen + 16'd1 : base_seen;
        copied     = (seen_inc < base_kept) ? seen_inc : base_kept;
        align      = 2'd3 + copied[1:0];

        o_cmd           = '0;
        o_cmd.data_byte = i_in.data_byte;
        o_cmd.blk_len   = base_blk;
        o_cmd.ts        = i_in.timestamp_us;
        o_cmd.packet    = packet;
        o_cmd.freq      = freq;
        o_cmd.flags     = flags;
        o_cmd.sig       = i_in.signal_dbm;

        if (!i_in.action) begin
            o_cmd.sec  = 1'b1;
            push       = 1'b1;
            n_in_frame = 1'b0;
        end else if (i_in.is_first || r_in_frame) begin
            o_cmd.hdr  = i_in.is_first;
            o_cmd.data = base_seen < base_kept;
            n_seen     = seen_inc;
            if (i_in.is_first) begin
                n_kept     = kept_new;
                n_blk      = blk_new;
                n_in_frame = 1'b1;
            end
            if (i_in.is_last) begin
                o_cmd.trl  = 1'b1;
                o_cmd.pad  = 2'd0 - align;
                n_in_frame = 1'b0;
            end
            push = o_cmd.hdr || o_cmd.data || o_cmd.trl;
        end
    end

    assign o_push = accept && push;

    // Frame tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kept     <= '0;
            r_seen     <= '0;
            r_blk      <= '0;
            r_in_frame <= 1'b0;
        end else if (accept) begin
            r_kept     <= n_kept;
            r_seen     <= n_seen;
            r_blk      <= n_blk;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

@@ hw/rtl/prf_queue.sv @@
`timescale 1ns / 1ps

module prf_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  prf_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output prf_pkg::t_cmd     o_head,
    output prf_pkg::t_q_stat  o_stat
);

    prf_pkg::t_cmd             r_mem [prf_pkg::QUEUE_DEPTH];
    logic [prf_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [prf_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [prf_pkg::QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_count == (prf_pkg::QPTR_W + 1)'(prf_pkg::QUEUE_DEPTH));
    assign o_stat.valid = (r_count != '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && o_stat.valid;
    assign o_head       = r_mem[r_rd_ptr];

    // Command storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/prf_back.sv @@
`timescale 1ns / 1ps

module prf_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prf_pkg::t_cmd     i_head,
    input  prf_pkg::t_q_stat  i_q_stat,
    output logic              o_pop,
    prf_out_if.source         o_out
);

    localparam logic [prf_pkg::CNT_W-1:0] SEC_END =
        prf_pkg::CNT_W'(prf_pkg::SEC_BYTES - 1);
    localparam logic [prf_pkg::CNT_W-1:0] HDR_END =
        prf_pkg::CNT_W'(prf_pkg::HDR_BYTES - 1);
    localparam logic [prf_pkg::CNT_W-1:0] TRL_END =
        prf_pkg::CNT_W'(prf_pkg::TRL_BYTES - 1);

    prf_pkg::t_phase            r_phase, n_phase;
    logic [prf_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;
    logic [7:0]                 r_out_byte, n_out_byte;
    logic                       r_out_last, n_out_last;

    prf_pkg::t_phase            start_phase;
    prf_pkg::t_phase            cur_phase;
    prf_pkg::t_phase            after_phase;
    logic [prf_pkg::CNT_W-1:0]  cur_cnt;
    logic                       out_free;
    logic                       fire;
    logic                       phase_end;
    logic                       done;
    logic [7:0]                 cur_byte;

    // Enhanced packet block header plus radiotap header, byte by byte
    function automatic logic [7:0] hdr_byte(input prf_pkg::t_cmd c,
                                            input logic [prf_pkg::CNT_W-1:0] idx);
        logic [7:0] b;
        b = 8'd0;
        case (idx)
            6'd0:    b = prf_pkg::EPB_TYPE;
            6'd4:    b = c.blk_len[7:0];
            6'd5:    b = c.blk_len[15:8];
            6'd6:    b = {7'd0, c.blk_len[16]};
            6'd16:   b = c.ts[7:0];
            6'd17:   b = c.ts[15:8];
            6'd18:   b = c.ts[23:16];
            6'd19:   b = c.ts[31:24];
            6'd20:   b = c.packet[7:0];
            6'd21:   b = c.packet[15:8];
            6'd24:   b = c.packet[7:0];
            6'd25:   b = c.packet[15:8];
            6'd30:   b = 8'(prf_pkg::RTAP_LEN);
            6'd32:   b = prf_pkg::RTAP_PRESENT;
            6'd38:   b = c.freq[7:0];
            6'd39:   b = c.freq[15:8];
            6'd40:   b = c.flags[7:0];
            6'd41:   b = c.flags[15:8];
            6'd42:   b = c.sig;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    // Phase that follows the data byte: padding, trailer or end
    function automatic prf_pkg::t_phase tail_phase(input prf_pkg::t_cmd c);
        prf_pkg::t_phase p;
        p = prf_pkg::PH_IDLE;
        if (c.trl) begin
            p = (c.pad != 2'd0) ? prf_pkg::PH_PAD : prf_pkg::PH_TRL;
        end
        return p;
    endfunction

    assign out_free = !r_out_valid || o_out.ready;
    assign fire     = i_q_stat.valid && out_free;

    // Sequencer: next phase, byte select and output register load
    always_comb begin
        if (i_head.sec) begin
            start_phase = prf_pkg::PH_SEC;
        end else if (i_head.hdr) begin
            start_phase = prf_pkg::PH_HDR;
        end else if (i_head.data) begin
            start_phase = prf_pkg::PH_DATA;
        end else begin
            start_phase = tail_phase(i_head);
        end

        cur_phase = (r_phase == prf_pkg::PH_IDLE) ? start_phase : r_phase;
        cur_cnt   = (r_phase == prf_pkg::PH_IDLE) ? '0 : r_cnt;

        cur_byte    = 8'd0;
        phase_end   = 1'b0;
        after_phase = prf_pkg::PH_IDLE;
        case (cur_phase)
            prf_pkg::PH_SEC: begin
                cur_byte  = prf_pkg::SECTION_BYTES[cur_cnt];
                phase_end = (cur_cnt == SEC_END);
            end
            prf_pkg::PH_HDR: begin
                cur_byte    = hdr_byte(i_head, cur_cnt);
                phase_end   = (cur_cnt == HDR_END);
                after_phase = i_head.data ? prf_pkg::PH_DATA : tail_phase(i_head);
            end
            prf_pkg::PH_DATA: begin
                cur_byte    = i_head.data_byte;
                phase_end   = 1'b1;
                after_phase = tail_phase(i_head);
            end
            prf_pkg::PH_PAD: begin
                phase_end   = (cur_cnt[1:0] == i_head.pad - 2'd1);
                after_phase = prf_pkg::PH_TRL;
            end
            prf_pkg::PH_TRL: begin
                case (cur_cnt[1:0])
                    2'd0:    cur_byte = i_head.blk_len[7:0];
                    2'd1:    cur_byte = i_head.blk_len[15:8];
                    2'd2:    cur_byte = {7'd0, i_head.blk_len[16]};
                    default: cur_byte = 8'd0;
                endcase
                phase_end = (cur_cnt == TRL_END);
            end
            default: begin
                cur_byte  = 8'd0;
                phase_end = 1'b1;
            end
        endcase
        done = phase_end && (after_phase == prf_pkg::PH_IDLE);

        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        if (fire) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_last  = done;
            o_pop       = done;
            if (phase_end) begin
                n_phase = after_phase;
                n_cnt   = '0;
            end else begin
                n_phase = cur_phase;
                n_cnt   = cur_cnt + 1'b1;
            end
        end
    end

    // Phase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= prf_pkg::PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

endmodule

@@ hw/rtl/pcapng_radiotap_framer.sv @@
`timescale 1ns / 1ps
// An accepted item's bytes pass through the command queue and the output register.
// Throughput: one output byte per cycle while the output is ready; frame data bytes
// are taken one per cycle while the queue has room. A section item emits 60 bytes, a
// first byte 43 header bytes plus its data byte, a last byte up to 7 trailer bytes;
// the 4-entry command queue absorbs these bursts. Reset (synchronous, active low)
// empties the queue, idles the output sequencer and clears frame tracking state.

module pcapng_radiotap_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    prf_in_if.sink     i_in,
    prf_out_if.source  o_out
);

    logic              push;
    logic              pop;
    prf_pkg::t_cmd     cmd;
    prf_pkg::t_cmd     head;
    prf_pkg::t_q_stat  q_stat;

    prf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    prf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    prf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

@@ hw/rtl/prf_checker.sv @@
`timescale 1ns / 1ps

module prf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // A stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last))
        else $error("output item changed while stalled");

    // Nothing comes out in the cycle after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // An item accepted right after reset cannot reach the output in the cycle after
    a_rst_latency: assert property (@(posedge i_clk)
        !i_rst_n |=> ##1 !i_out_valid)
        else $error("output valid before any accepted item could reach it");

    // Empty queue after reset takes input at once
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

endmodule

bind pcapng_radiotap_framer prf_checker u_prf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.run_last)
);

@@ tb/pcapng_tb_pkg.sv @@
`timescale 1ns / 1ps

package pcapng_tb_pkg;

    // Input item actions
    typedef enum logic {
        ACT_SECTION    = 1'b0,
        ACT_FRAME_BYTE = 1'b1
    } t_action;

endpackage

@@ tb/pcapng_stream_check.sv @@
`timescale 1ns / 1ps

// Watches both channels, builds the PCAPNG byte stream that each accepted
// input item should produce, and compares it with what comes out.
module pcapng_stream_check (
    input  logic i_clk,
    input  logic i_rst_n,
    prf_in_if    i_in_mon,
    prf_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_bytes_checked
);

    // Block and field codes of the capture format
    localparam logic [31:0] BT_SECTION      = 32'h0a0d0d0a;
    localparam logic [31:0] BT_IFACE        = 32'd1;
    localparam logic [31:0] BT_PACKET       = 32'd6;
    localparam logic [31:0] BYTE_ORDER      = 32'h1a2b3c4d;
    localparam logic [31:0] SHB_LEN         = 32'd28;
    localparam logic [31:0] IDB_LEN         = 32'd32;
    localparam logic [31:0] LINK_RADIOTAP   = 32'd127;
    localparam logic [31:0] SNAP_BYTES      = 32'd65535;
    localparam logic [31:0] OPT_TS_RESOL    = 32'd9;
    localparam logic [31:0] TS_RESOL_US     = 32'd6;
    localparam logic [31:0] RTAP_BYTES      = 32'd15;
    localparam logic [31:0] RTAP_FIELDS     = 32'h2a;
    localparam logic [15:0] KEEP_LIMIT      = 16'(SNAP_BYTES - RTAP_BYTES);
    localparam int          REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
    } t_stream_byte;

    t_stream_byte expected_stream[$];

    // Frame tracking
    logic [15:0] kept_len   = '0;
    logic [15:0] seen_cnt   = '0;
    logic [16:0] blk_len    = '0;
    logic        frame_open = 1'b0;

    int mismatches = 0;
    int checked    = 0;

    function automatic logic [15:0] channel_mhz(input logic [7:0] ch);
        if (ch == 8'd0) return 16'd0;
        if (ch <= 8'd13) return 16'd2407 + 16'd5 * {8'd0, ch};
        if (ch == 8'd14) return 16'd2484;
        return 16'd5000 + 16'd5 * {8'd0, ch};
    endfunction

    function automatic logic [15:0] band_flags(input logic [7:0] ch);
        if (ch == 8'd0) return 16'h0000;
        return (ch <= 8'd14) ? 16'h00c0 : 16'h0140;
    endfunction

    // Little-endian append of the low nbytes of v
    task automatic push_le(input logic [31:0] v, input int nbytes);
        t_stream_byte b;
        for (int k = 0; k < nbytes; k++) begin
            b = {v[8*k +: 8], 1'b0};
            expected_stream.push_back(b);
        end
    endtask

    task automatic predict_item(
        input logic        act,
        input logic [15:0] flen,
        input logic [31:0] ts,
        input logic [7:0]  ch,
        input logic [7:0]  sig,
        input logic [7:0]  dbyte,
        input logic        first,
        input logic        last
    );
        int            start_size;
        logic [31:0]   packet;
        logic [31:0]   copied;
        logic [31:0]   pad;
        t_stream_byte  tail;

        start_size = expected_stream.size();

        if (act == pcapng_tb_pkg::ACT_SECTION) begin
            frame_open = 1'b0;
            // section header block
            push_le(BT_SECTION, 4);
            push_le(SHB_LEN, 4);
            push_le(BYTE_ORDER, 4);
            push_le(32'd1, 2);
            push_le(32'd0, 2);
            push_le(32'hffff_ffff, 4);
            push_le(32'hffff_ffff, 4);
            push_le(SHB_LEN, 4);
            // interface description with microsecond resolution option
            push_le(BT_IFACE, 4);
            push_le(IDB_LEN, 4);
            push_le(LINK_RADIOTAP, 2);
            push_le(32'd0, 2);
            push_le(SNAP_BYTES, 4);
            push_le(OPT_TS_RESOL, 2);
            push_le(32'd1, 2);
            push_le(TS_RESOL_US, 4);
            push_le(32'd0, 4);
            push_le(IDB_LEN, 4);
        end else begin
            if (first) begin
                kept_len   = (flen > KEEP_LIMIT) ? KEEP_LIMIT : flen;
                packet     = RTAP_BYTES + 32'(kept_len);
                blk_len    = 17'(32'd32 + ((packet + 32'd3) & ~32'd3));
                seen_cnt   = '0;
                frame_open = 1'b1;
                // enhanced packet block header
                push_le(BT_PACKET, 4);
                push_le(32'(blk_len), 4);
                push_le(32'd0, 4);
                push_le(32'd0, 4);
                push_le(ts, 4);
                push_le(packet, 4);
                push_le(packet, 4);
                // radiotap header
                push_le(32'd0, 2);
                push_le(RTAP_BYTES, 2);
                push_le(RTAP_FIELDS, 4);
                push_le(32'd0, 2);
                push_le(32'(channel_mhz(ch)), 2);
                push_le(32'(band_flags(ch)), 2);
                push_le(32'(sig), 1);
            end

            // data byte, snap drop, trailer
            if (frame_open) begin
                if (seen_cnt < kept_len) push_le(32'(dbyte), 1);
                if (seen_cnt != 16'hffff) seen_cnt = seen_cnt + 16'd1;
                if (last) begin
                    copied = (seen_cnt < kept_len) ? 32'(seen_cnt) : 32'(kept_len);
                    pad    = (32'd4 - ((RTAP_BYTES + copied) & 32'd3)) & 32'd3;
                    push_le(32'd0, int'(pad));
                    push_le(32'(blk_len), 4);
                    frame_open = 1'b0;
                end
            end
        end

        // mark the end of this item's run
        if (expected_stream.size() > start_size) begin
            tail = expected_stream.pop_back();
            tail.run_last = 1'b1;
            expected_stream.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin : monitor_proc
        t_stream_byte want;
        if (!i_rst_n) begin
            expected_stream.delete();
            kept_len   = '0;
            seen_cnt   = '0;
            blk_len    = '0;
            frame_open = 1'b0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                predict_item(i_in_mon.action, i_in_mon.frame_length, i_in_mon.timestamp_us,
                             i_in_mon.radio_channel, i_in_mon.signal_dbm,
                             i_in_mon.data_byte, i_in_mon.is_first, i_in_mon.is_last);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_stream.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("ERROR: unexpected stream byte %02h last=%0b at %0t",
                                 i_out_mon.out_byte, i_out_mon.run_last, $time);
                end else begin
                    want = expected_stream.pop_front();
                    if (i_out_mon.out_byte !== want.value ||
                        i_out_mon.run_last !== want.run_last) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("ERROR: stream byte %0d: expected %02h last=%0b, got %02h last=%0b",
                                     checked, want.value, want.run_last,
                                     i_out_mon.out_byte, i_out_mon.run_last);
                    end
                    checked++;
                end
            end
        end
        o_fail_count    <= mismatches;
        o_pending       <= expected_stream.size();
        o_bytes_checked <= checked;
    end

endmodule

@@ tb/tb_pcapng_radiotap_framer.sv @@
`timescale 1ns / 1ps

module tb_pcapng_radiotap_framer;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 270;
    localparam int QUIET_FROM   = 220;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet_tail = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   items_sent = 0;
    int   frames_sent = 0;
    int   sections_sent = 0;
    int   fail_count;
    int   pending;
    int   bytes_checked;

    prf_in_if  in_ch ();
    prf_out_if out_ch ();

    pcapng_radiotap_framer uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    pcapng_stream_check u_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Output side: random stall bursts, none near the end
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left   <= $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no input item accepted
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("ERROR: no input accepted for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    function automatic logic [7:0] random_channel();
        if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 16));
        return 8'($urandom);
    endfunction

    // Present one item and hold it until taken, with an occasional gap first
    task automatic send_item(
        input logic        act,
        input logic [15:0] flen,
        input logic [31:0] ts,
        input logic [7:0]  ch,
        input logic [7:0]  sig,
        input logic [7:0]  dbyte,
        input logic        first,
        input logic        last
    );
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.frame_length  <= flen;
        in_ch.timestamp_us  <= ts;
        in_ch.radio_channel <= ch;
        in_ch.signal_dbm    <= sig;
        in_ch.data_byte     <= dbyte;
        in_ch.is_first      <= first;
        in_ch.is_last       <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        items_sent++;
    endtask

    // Section start; the other fields carry noise
    task automatic send_section();
        send_item(pcapng_tb_pkg::ACT_SECTION, 16'($urandom), $urandom, 8'($urandom),
                  8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        sections_sent++;
    endtask

    // Stray data byte with no first marker
    task automatic send_stray(input logic last);
        send_item(pcapng_tb_pkg::ACT_FRAME_BYTE, 16'($urandom), $urandom, 8'($urandom),
                  8'($urandom), 8'($urandom), 1'b0, last);
    endtask

    // One frame of nbytes; header fields ride on the first byte only
    task automatic send_frame(
        input int          nbytes,
        input logic [15:0] flen,
        input logic [31:0] ts,
        input logic [7:0]  ch,
        input logic [7:0]  sig,
        input logic        close
    );
        for (int i = 0; i < nbytes; i++) begin
            if (i == 0)
                send_item(pcapng_tb_pkg::ACT_FRAME_BYTE, flen, ts, ch, sig, 8'($urandom),
                          1'b1, close && nbytes == 1);
            else
                send_item(pcapng_tb_pkg::ACT_FRAME_BYTE, 16'($urandom), $urandom,
                          8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                          close && i == nbytes - 1);
        end
        frames_sent++;
    endtask

    initial begin : stimulus
        int          random_items;
        int          nbytes;
        int          pick;
        logic [15:0] flen;

        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= pcapng_tb_pkg::ACT_SECTION;
        in_ch.frame_length  <= '0;
        in_ch.timestamp_us  <= '0;
        in_ch.radio_channel <= '0;
        in_ch.signal_dbm    <= '0;
        in_ch.data_byte     <= '0;
        in_ch.is_first      <= 1'b0;
        in_ch.is_last       <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: headers, channel bands, signal extremes, corner frames
        send_section();
        send_frame(1, 16'd1, 32'h0000_0000, 8'd1, 8'h80, 1'b1);
        send_frame(3, 16'd3, 32'hffff_ffff, 8'd14, 8'h7f, 1'b1);
        send_stray(1'b1);                                     // outside a frame
        send_frame(1, 16'd0, 32'h1234_5678, 8'd0, 8'h00, 1'b1);  // zero length
        send_frame(2, 16'hffff, 32'h8000_0001, 8'd13, 8'hc4, 1'b0);
        send_frame(2, 16'd2, 32'h0000_ffff, 8'd15, 8'hff, 1'b1);  // restarts open frame
        send_frame(2, 16'd5, 32'hffff_0000, 8'd255, 8'h01, 1'b0);
        send_section();                                       // closes open frame
        send_stray(1'b0);
        send_frame(2, 16'd10, 32'h5555_aaaa, 8'd36, 8'hb0, 1'b1);  // early last
        send_frame(4, 16'd2, 32'haaaa_5555, 8'd165, 8'hd8, 1'b1);  // bytes dropped
        send_frame(4, 16'd65520, 32'h0f0f_f0f0, 8'd200, 8'he2, 1'b1);

        // Random: mostly well-formed frames, some sections, noise and broken frames
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= QUIET_FROM) quiet_tail <= 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_section();
                random_items++;
            end else if (pick < 12) begin
                send_stray(1'($urandom));
                random_items++;
            end else begin
                nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 70)
                                                     : $urandom_range(1, 12);
                case ($urandom_range(0, 9))
                    6:       flen = 16'($urandom_range(0, nbytes));
                    7:       flen = 16'($urandom_range(nbytes, nbytes + 20));
                    8:       flen = 16'($urandom);
                    9:       flen = 16'($urandom_range(65500, 65535));
                    default: flen = 16'(nbytes);
                endcase
                send_frame(nbytes, flen, $urandom, random_channel(), 8'($urandom),
                           $urandom_range(0, 19) != 0);
                random_items += nbytes;
            end
        end
        in_ch.valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input items: %0d frames and %0d section starts,",
                 items_sent, frames_sent, sections_sent);
        $display("with stray, abandoned, early-ended and clipped frames; %0d stream bytes compared.",
                 bytes_checked);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
